@@ rtl/core/bsm_pkg.sv @@
// Shared types and constants for the background subtraction motion mask block.
`default_nettype none
package bsm_pkg;

  localparam int IDX_W     = 18;
  localparam int CHAN_W    = 16;
  localparam int LUMA_W    = 11;
  localparam int MASK_W    = 8;
  localparam int THR_W     = 8;
  localparam int FMT_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;

  localparam logic [2:0]        LUMA_GAIN = 3'd7;
  localparam logic [MASK_W-1:0] MASK_ON   = 8'hFF;
  localparam logic [MASK_W-1:0] MASK_OFF  = 8'h00;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 1'b1;

  typedef enum logic [FMT_W-1:0] {
    FMT_RGB8   = 2'd0,
    FMT_LUMA8  = 2'd1,
    FMT_RGB16  = 2'd2,
    FMT_LUMA16 = 2'd3
  } fmt_t;

  typedef enum logic {
    OP_LEARN   = 1'b0,
    OP_COMPARE = 1'b1
  } op_t;

  typedef struct packed {
    op_t               operation;
    logic [IDX_W-1:0]  pixel_index;
    logic [CHAN_W-1:0] chan_a;
    logic [CHAN_W-1:0] chan_b;
    logic [CHAN_W-1:0] chan_c;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [IDX_W-1:0]  out_index;
  } out_item_t;

endpackage
`default_nettype wire

@@ rtl/core/bsm_luma.sv @@
// Fake luma reduction of one pixel for each supported pixel format.
`default_nettype none
module bsm_luma (
  input  wire bsm_pkg::fmt_t                  fmt,
  input  wire logic [bsm_pkg::CHAN_W-1:0]     chan_a,
  input  wire logic [bsm_pkg::CHAN_W-1:0]     chan_b,
  input  wire logic [bsm_pkg::CHAN_W-1:0]     chan_c,
  output logic      [bsm_pkg::LUMA_W-1:0]     luma
);

  localparam int LW = bsm_pkg::LUMA_W;

  logic [7:0]    y8;
  logic [LW-1:0] y_x7;

  always_comb begin
    y8 = (fmt == bsm_pkg::FMT_LUMA16) ? chan_a[15:8] : chan_a[7:0];
    y_x7 = LW'({y8, 3'b000}) - LW'(y8);
    case (fmt)
      bsm_pkg::FMT_RGB8: begin
        luma = LW'({chan_a[7:0], 1'b0}) + LW'({chan_b[7:0], 2'b00}) + LW'(chan_c[7:0]);
      end
      bsm_pkg::FMT_RGB16: begin
        luma = LW'(chan_a[15:7]) + LW'(chan_b[15:6]) + LW'(chan_c[15:8]);
      end
      bsm_pkg::FMT_LUMA8,
      bsm_pkg::FMT_LUMA16: begin
        luma = y_x7;
      end
      default: begin
        luma = y_x7;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/bsm_addr_reduce.sv @@
// Two-stage reduction of the pixel index modulo the store depth.
`default_nettype none
module bsm_addr_reduce #(
  parameter int PIXELS = 262144
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [bsm_pkg::IDX_W-1:0]      idx_i,
  output logic      [$clog2(PIXELS)-1:0]      addr_o
);

  localparam int AW      = $clog2(PIXELS);
  localparam int IW      = bsm_pkg::IDX_W;
  localparam int RECIP   = (1 << IW) / PIXELS;
  localparam int RECIP_W = IW - 1;
  localparam int P1_W    = IW + RECIP_W;
  localparam int QP_W    = RECIP_W + AW + 1;
  localparam int RW      = ((AW > IW) ? AW : IW) + 1;

  logic [P1_W-1:0]    p1;
  logic [RECIP_W-1:0] q_r;
  logic [IW-1:0]      idx_r;
  logic [QP_W-1:0]    qp;
  logic [IW-1:0]      rem_nxt;
  logic [IW-1:0]      rem_r;
  logic [RW-1:0]      rem_x;
  logic [RW-1:0]      addr_full;

  // quotient estimate is exact or one short
  assign p1 = P1_W'(idx_i) * P1_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      q_r   <= p1[P1_W-1:IW];
      idx_r <= idx_i;
    end
  end

  assign qp      = QP_W'(q_r) * QP_W'(PIXELS);
  assign rem_nxt = idx_r - qp[IW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
    end
  end

  always_comb begin
    rem_x     = RW'(rem_r);
    addr_full = (rem_x >= RW'(PIXELS)) ? (rem_x - RW'(PIXELS)) : rem_x;
    addr_o    = addr_full[AW-1:0];
  end

endmodule
`default_nettype wire

@@ rtl/core/bsm_bg_mem.sv @@
// Single-port background luma store with registered read data.
`default_nettype none
module bsm_bg_mem #(
  parameter int PIXELS = 262144
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic                           we,
  input  wire logic [$clog2(PIXELS)-1:0]      addr,
  input  wire logic [bsm_pkg::LUMA_W-1:0]     wdata,
  output logic      [bsm_pkg::LUMA_W-1:0]     rdata
);

  logic [bsm_pkg::LUMA_W-1:0] mem_r [PIXELS];
  logic [bsm_pkg::LUMA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/core/background_subtract_motion_mask.sv @@
// Top level of the per-pixel background subtraction motion detector.
// Accepts one pixel beat per clock unless stalled and holds a one-port
// store of PIXELS 11-bit luma entries, one access per pixel: a learn
// beat writes the pixel's fake luma, a compare beat reads the entry and
// returns one result beat with mask 255 when the luma difference exceeds
// threshold*7. Sustained rate is one pixel per cycle when not stalled; a
// compare result reaches the output register through the index reduction
// registers, the store read register and the compare. Learn beats produce
// no result. The whole pipeline stalls only while a result waits at the
// output. Store entries hold no value until learned and are not cleared.
`default_nettype none
module background_subtract_motion_mask #(
  parameter int PIXELS = 262144
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire bsm_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output bsm_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [bsm_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [bsm_pkg::CFG_DAT_W-1:0]     cfg_data
);

  localparam int AW = $clog2(PIXELS);
  localparam int LW = bsm_pkg::LUMA_W;
  localparam int IW = bsm_pkg::IDX_W;

  bsm_pkg::fmt_t            fmt_r;
  logic [bsm_pkg::THR_W-1:0] thr_r;

  logic adv;

  logic          v1_r, v2_r, v3_r;
  bsm_pkg::op_t  op1_r, op2_r, op3_r;
  logic [IW-1:0] idx1_r, idx2_r, idx3_r;
  logic [LW-1:0] luma1_r, luma2_r, luma3_r;
  logic [LW-1:0] luma_in;

  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [LW-1:0] bg;

  logic [LW-1:0]      diff;
  logic [LW-1:0]      limit;
  bsm_pkg::out_item_t out_nxt;
  bsm_pkg::out_item_t out_r;
  logic               out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= bsm_pkg::FMT_RGB8;
      thr_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        bsm_pkg::CFG_PIXEL_FORMAT: fmt_r <= bsm_pkg::fmt_t'(cfg_data[bsm_pkg::FMT_W-1:0]);
        bsm_pkg::CFG_THRESHOLD:    thr_r <= cfg_data[bsm_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  bsm_luma u_luma (
    .fmt    (fmt_r),
    .chan_a (in_data.chan_a),
    .chan_b (in_data.chan_b),
    .chan_c (in_data.chan_c),
    .luma   (luma_in)
  );

  bsm_addr_reduce #(.PIXELS(PIXELS)) u_addr (
    .clk    (clk),
    .en     (adv),
    .idx_i  (in_data.pixel_index),
    .addr_o (mem_addr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r   <= in_data.operation;
      idx1_r  <= in_data.pixel_index;
      luma1_r <= luma_in;
      op2_r   <= op1_r;
      idx2_r  <= idx1_r;
      luma2_r <= luma1_r;
      op3_r   <= op2_r;
      idx3_r  <= idx2_r;
      luma3_r <= luma2_r;
    end
  end

  assign mem_we = v2_r && (op2_r == bsm_pkg::OP_LEARN);

  bsm_bg_mem #(.PIXELS(PIXELS)) u_mem (
    .clk   (clk),
    .en    (adv),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (luma2_r),
    .rdata (bg)
  );

  always_comb begin
    diff  = (luma3_r >= bg) ? (luma3_r - bg) : (bg - luma3_r);
    limit = LW'({thr_r, 3'b000}) - LW'(thr_r);
    out_nxt.mask      = (diff > limit) ? bsm_pkg::MASK_ON : bsm_pkg::MASK_OFF;
    out_nxt.out_index = idx3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v3_r && (op3_r == bsm_pkg::OP_COMPARE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
